// File: design/cof_pkg.sv
// shared types, codes and constants of the cursor overlay compositor
`default_nettype none
package cof_pkg;

  localparam int SHAPE_WORDS_DEF    = 4096;
  localparam int MAX_CURSOR_DIM_DEF = 64;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 24;
  localparam int BA_W        = 17;
  localparam int UWA_W       = 15;
  localparam int QWA_W       = 16;
  localparam int Q_DEPTH     = 4;

  localparam logic [1:0] CT_COLOR  = 2'd0;
  localparam logic [1:0] CT_MONO   = 2'd1;
  localparam logic [1:0] CT_MASKED = 2'd2;
  localparam logic [1:0] CT_OFF    = 2'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_PITCH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

  typedef struct packed {
    logic [1:0]  ctype;
    logic [12:0] cx;
    logic [12:0] cy;
    logic [6:0]  sw;
    logic [7:0]  sh;
    logic [8:0]  pitch;
    logic [12:0] fw;
    logic [12:0] fh;
  } cof_cfg_t;

  typedef struct packed {
    logic             is_pix;
    logic             hit;
    logic [1:0]       ctype;
    logic [23:0]      bgr;
    logic [31:0]      wdata;
    logic [QWA_W-1:0] w0;
    logic [QWA_W-1:0] w1;
    logic [1:0]       off0;
    logic [1:0]       off1;
    logic [2:0]       bitsel;
  } cof_item_t;

endpackage
`default_nettype wire

// File: design/cof_front.sv
// front pipeline: hit test, shape byte addressing and word address wrap
`default_nettype none
module cof_front #(
  parameter int SHAPE_WORDS    = cof_pkg::SHAPE_WORDS_DEF,
  parameter int MAX_CURSOR_DIM = cof_pkg::MAX_CURSOR_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire cof_pkg::cof_cfg_t               cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [cof_pkg::IN_TDATA_W-1:0]  in_data,
  input  wire logic                            in_mode,
  output logic                                 push,
  output cof_pkg::cof_item_t                   push_item,
  input  wire logic                            full
);

  localparam int AW_L      = $clog2(SHAPE_WORDS);
  localparam int MOD_STEPS = (AW_L >= 16) ? 0 : 16 - AW_L;
  localparam int MOD_HALF  = MOD_STEPS / 2;
  localparam logic [8:0] SW_LIM = 9'(MAX_CURSOR_DIM);
  localparam logic [9:0] SH_LIM = 10'(2 * MAX_CURSOR_DIM);

  // partial restoring reduction modulo the memory depth
  function automatic logic [15:0] mod_part(input logic [15:0] v, input int hi, input int lo);
    logic [16:0] r;
    r = {1'b0, v};
    for (int j = hi; j >= lo; j--) begin
      if (r >= (17'(SHAPE_WORDS) << j)) begin
        r = r - (17'(SHAPE_WORDS) << j);
      end
    end
    return r[15:0];
  endfunction

  logic fen;

  // stage 1 comb
  logic [11:0] px, py, waddr;
  logic [31:0] wdata;
  logic [23:0] bgr;
  logic [13:0] sx, sy;
  logic [6:0]  sw_sat;
  logic [7:0]  sh_sat, sh_eff;
  logic        hit_nxt;

  logic        s1_v_r, s1_mode_r, s1_hit_r;
  logic [11:0] s1_waddr_r;
  logic [31:0] s1_wdata_r;
  logic [23:0] s1_bgr_r;
  logic [1:0]  s1_type_r;
  logic [6:0]  s1_ux_r;
  logic [7:0]  s1_uy_r, s1_she_r;

  logic [7:0]  shx;
  logic [16:0] row_nxt, xrow_nxt;

  logic        s2_v_r, s2_mode_r, s2_hit_r;
  logic [11:0] s2_waddr_r;
  logic [31:0] s2_wdata_r;
  logic [23:0] s2_bgr_r;
  logic [1:0]  s2_type_r;
  logic [6:0]  s2_ux_r;
  logic [16:0] s2_row_r, s2_xrow_r;

  logic [8:0]  col_off;
  logic [16:0] baddr, xaddr;
  logic [14:0] w0_nxt, w1_nxt;

  logic        s3_v_r, s3_mode_r, s3_hit_r;
  logic [31:0] s3_wdata_r;
  logic [23:0] s3_bgr_r;
  logic [1:0]  s3_type_r, s3_off0_r, s3_off1_r;
  logic [2:0]  s3_bit_r;
  logic [14:0] s3_w0_r, s3_w1_r;

  logic        s4_v_r, s4_mode_r, s4_hit_r;
  logic [31:0] s4_wdata_r;
  logic [23:0] s4_bgr_r;
  logic [1:0]  s4_type_r, s4_off0_r, s4_off1_r;
  logic [2:0]  s4_bit_r;
  logic [15:0] s4_w0_r, s4_w1_r;

  logic               s5_v_r;
  cof_pkg::cof_item_t s5_item_r;
  cof_pkg::cof_item_t item_nxt;

  assign fen       = !s5_v_r || !full;
  assign in_ready  = fen;
  assign push      = s5_v_r && !full;
  assign push_item = s5_item_r;

  assign waddr = in_data[11:0];
  assign wdata = in_data[43:12];
  assign px    = in_data[55:44];
  assign py    = in_data[67:56];
  assign bgr   = in_data[91:68];

  always_comb begin
    sx     = {2'b00, px} - {cfg.cx[12], cfg.cx};
    sy     = {2'b00, py} - {cfg.cy[12], cfg.cy};
    sw_sat = ({2'b00, cfg.sw} > SW_LIM) ? SW_LIM[6:0] : cfg.sw;
    sh_sat = ({2'b00, cfg.sh} > SH_LIM) ? SH_LIM[7:0] : cfg.sh;
    sh_eff = (cfg.ctype == cof_pkg::CT_MONO) ? {1'b0, sh_sat[7:1]} : sh_sat;
    hit_nxt = (in_mode == cof_pkg::MODE_PIXEL) && (cfg.ctype != cof_pkg::CT_OFF) &&
              (sw_sat != 7'd0) && (sh_eff != 8'd0) &&
              ({1'b0, px} < cfg.fw) && ({1'b0, py} < cfg.fh) &&
              !sx[13] && !sy[13] &&
              (sx[12:0] < {6'b0, sw_sat}) && (sy[12:0] < {5'b0, sh_eff});
  end

  assign shx      = s1_uy_r + s1_she_r;
  assign row_nxt  = {9'b0, s1_uy_r} * {8'b0, cfg.pitch};
  assign xrow_nxt = {9'b0, shx} * {8'b0, cfg.pitch};

  always_comb begin
    col_off = (s2_type_r == cof_pkg::CT_MONO) ? {5'b0, s2_ux_r[6:3]} : {s2_ux_r, 2'b00};
    baddr   = s2_row_r + {8'b0, col_off};
    xaddr   = s2_xrow_r + {13'b0, s2_ux_r[6:3]};
    w0_nxt  = (s2_mode_r == cof_pkg::MODE_PIXEL) ? baddr[16:2] : {3'b000, s2_waddr_r};
    w1_nxt  = (s2_type_r == cof_pkg::CT_MONO) ? xaddr[16:2] : baddr[16:2] + 15'd1;
  end

  always_comb begin
    item_nxt.is_pix = s4_mode_r;
    item_nxt.hit    = s4_hit_r;
    item_nxt.ctype  = s4_type_r;
    item_nxt.bgr    = s4_bgr_r;
    item_nxt.wdata  = s4_wdata_r;
    item_nxt.w0     = mod_part(s4_w0_r, MOD_HALF - 1, 0);
    item_nxt.w1     = mod_part(s4_w1_r, MOD_HALF - 1, 0);
    item_nxt.off0   = s4_off0_r;
    item_nxt.off1   = s4_off1_r;
    item_nxt.bitsel = s4_bit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (fen) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      s1_mode_r  <= in_mode;
      s1_hit_r   <= hit_nxt;
      s1_waddr_r <= waddr;
      s1_wdata_r <= wdata;
      s1_bgr_r   <= bgr;
      s1_type_r  <= cfg.ctype;
      s1_ux_r    <= sx[6:0];
      s1_uy_r    <= sy[7:0];
      s1_she_r   <= sh_eff;

      s2_mode_r  <= s1_mode_r;
      s2_hit_r   <= s1_hit_r;
      s2_waddr_r <= s1_waddr_r;
      s2_wdata_r <= s1_wdata_r;
      s2_bgr_r   <= s1_bgr_r;
      s2_type_r  <= s1_type_r;
      s2_ux_r    <= s1_ux_r;
      s2_row_r   <= row_nxt;
      s2_xrow_r  <= xrow_nxt;

      s3_mode_r  <= s2_mode_r;
      s3_hit_r   <= s2_hit_r;
      s3_wdata_r <= s2_wdata_r;
      s3_bgr_r   <= s2_bgr_r;
      s3_type_r  <= s2_type_r;
      s3_off0_r  <= baddr[1:0];
      s3_off1_r  <= xaddr[1:0];
      s3_bit_r   <= s2_ux_r[2:0];
      s3_w0_r    <= w0_nxt;
      s3_w1_r    <= w1_nxt;

      s4_mode_r  <= s3_mode_r;
      s4_hit_r   <= s3_hit_r;
      s4_wdata_r <= s3_wdata_r;
      s4_bgr_r   <= s3_bgr_r;
      s4_type_r  <= s3_type_r;
      s4_off0_r  <= s3_off0_r;
      s4_off1_r  <= s3_off1_r;
      s4_bit_r   <= s3_bit_r;
      s4_w0_r    <= mod_part({1'b0, s3_w0_r}, MOD_STEPS - 1, MOD_HALF);
      s4_w1_r    <= mod_part({1'b0, s3_w1_r}, MOD_STEPS - 1, MOD_HALF);

      s5_item_r  <= item_nxt;
    end
  end

  a_hit_needs_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_hit_r |-> s1_type_r != cof_pkg::CT_OFF && s1_mode_r == cof_pkg::MODE_PIXEL)
    else $error("hit flagged with cursor off or on a shape write");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s5_v_r && full |-> !in_ready && !push)
    else $error("front advanced into a full queue");

endmodule
`default_nettype wire

// File: design/cof_queue.sv
// short request queue between the front and back pipelines
`default_nettype none
module cof_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire cof_pkg::cof_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output cof_pkg::cof_item_t      pop_item,
  output logic                    empty
);

  localparam int PTR_W = $clog2(cof_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(cof_pkg::Q_DEPTH + 1);

  cof_pkg::cof_item_t slots_r [cof_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full     = (count_r == CNT_W'(cof_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");

endmodule
`default_nettype wire

// File: design/cof_back.sv
// back pipeline: shape memory, shape byte extraction, blend and output register
`default_nettype none
module cof_back #(
  parameter int SHAPE_WORDS = cof_pkg::SHAPE_WORDS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             empty,
  input  wire cof_pkg::cof_item_t               pop_item,
  output logic                                  pop,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [cof_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tuser
);

  localparam int WA_W = $clog2(SHAPE_WORDS);

  logic [31:0] shape_mem [SHAPE_WORDS];

  logic ben;

  logic [31:0] rd0_r, rd1_r;
  logic        v1_r, hit1_r;
  logic [1:0]  type1_r, off0_1_r, off1_1_r;
  logic [2:0]  bit1_r;
  logic [23:0] bgr1_r;

  logic [63:0] wide;
  logic [31:0] xsh;

  logic        v2_r, hit2_r, am2_r, xm2_r;
  logic [1:0]  type2_r;
  logic [23:0] bgr2_r, s2_r;
  logic [7:0]  a2_r;

  logic [2:0][15:0] p_nxt;

  logic        v3_r, hit3_r, am3_r, xm3_r;
  logic [1:0]  type3_r;
  logic [23:0] bgr3_r, s3_r;
  logic [7:0]  a3_r;
  logic [2:0][15:0] p3_r;

  logic [16:0] t0, t1, t2;
  logic [23:0] blend, res;

  logic        out_valid_r, out_hit_r;
  logic [23:0] out_data_r;

  assign ben        = !out_valid_r || out_tready;
  assign pop        = ben && !empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  always_ff @(posedge clk) begin
    if (pop && (pop_item.is_pix == cof_pkg::MODE_WRITE)) begin
      shape_mem[pop_item.w0[WA_W-1:0]] <= pop_item.wdata;
    end
    if (ben) begin
      rd0_r <= shape_mem[pop_item.w0[WA_W-1:0]];
      rd1_r <= shape_mem[pop_item.w1[WA_W-1:0]];
    end
  end

  // color bytes may straddle two words
  assign wide = {rd1_r, rd0_r} >> {off0_1_r, 3'b000};
  assign xsh  = rd1_r >> {off1_1_r, 3'b000};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p_nxt[c] = {8'b0, s2_r[8*c +: 8]} * {8'b0, a2_r} +
                 {8'b0, bgr2_r[8*c +: 8]} * {8'b0, 8'd255 - a2_r};
    end
  end

  // floor division by 255, exact below 65535
  assign t0 = {1'b0, p3_r[0]} + {9'b0, p3_r[0][15:8]} + 17'd1;
  assign t1 = {1'b0, p3_r[1]} + {9'b0, p3_r[1][15:8]} + 17'd1;
  assign t2 = {1'b0, p3_r[2]} + {9'b0, p3_r[2][15:8]} + 17'd1;
  assign blend = {t2[15:8], t1[15:8], t0[15:8]};

  always_comb begin
    res = bgr3_r;
    if (hit3_r) begin
      unique case (type3_r)
        cof_pkg::CT_COLOR: begin
          if (a3_r != 8'd0) begin
            res = blend;
          end
        end
        cof_pkg::CT_MONO: begin
          if (!am3_r) begin
            res = xm3_r ? 24'hFFFFFF : 24'h000000;
          end else if (xm3_r) begin
            res = ~bgr3_r;
          end
        end
        cof_pkg::CT_MASKED: begin
          res = (a3_r == 8'd0) ? s3_r : (bgr3_r ^ s3_r);
        end
        default: begin
          res = bgr3_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ben) begin
      v1_r        <= pop && (pop_item.is_pix == cof_pkg::MODE_PIXEL);
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      hit1_r   <= pop_item.hit;
      type1_r  <= pop_item.ctype;
      bgr1_r   <= pop_item.bgr;
      off0_1_r <= pop_item.off0;
      off1_1_r <= pop_item.off1;
      bit1_r   <= pop_item.bitsel;

      hit2_r  <= hit1_r;
      type2_r <= type1_r;
      bgr2_r  <= bgr1_r;
      s2_r    <= wide[23:0];
      a2_r    <= wide[31:24];
      am2_r   <= wide[{3'b000, ~bit1_r}];
      xm2_r   <= xsh[{2'b00, ~bit1_r}];

      hit3_r  <= hit2_r;
      type3_r <= type2_r;
      bgr3_r  <= bgr2_r;
      s3_r    <= s2_r;
      a3_r    <= a2_r;
      am3_r   <= am2_r;
      xm3_r   <= xm2_r;
      p3_r    <= p_nxt;

      out_data_r <= res;
      out_hit_r  <= hit3_r;
    end
  end

  a_miss_passes_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    ben && v3_r && !hit3_r |=> out_data_r == $past(bgr3_r) && !out_hit_r)
    else $error("pixel outside cursor was altered");

endmodule
`default_nettype wire

// File: design/cursor_overlay_compositor_core.sv
// top level of the cursor overlay compositor: config registers and pipeline wiring
// Takes one request per clock unless stalled, shape word writes and frame pixels alike,
// and returns one composited pixel per pixel request in request order; shape writes
// return nothing. A pixel's result passes ten register stages (five front stages, the
// queue, the registered shape memory read, two blend stages and the output register)
// before it is offered. The rate of one request per cycle, when not stalled, is set by
// the shape memory, which serves one write or one pair of reads each cycle. The shape
// memory is not cleared: every shape word the cursor uses must be written first.
// Write registers only while no pixel is in flight; the block itself does not enforce it.
`default_nettype none
module cursor_overlay_compositor_core #(
  parameter int SHAPE_WORDS    = cof_pkg::SHAPE_WORDS_DEF,
  parameter int MAX_CURSOR_DIM = cof_pkg::MAX_CURSOR_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // shape_word_addr[11:0], shape_word[43:12], pixel_x[55:44], pixel_y[67:56],
  // pixel_bgr[91:68], zero[95:92]
  input  wire logic [cof_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[0]
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_bgr[23:0]
  output logic [cof_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // cursor_hit[0]
  output logic                                 out_tuser,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cof_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cof_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cof_pkg::cof_cfg_t  cfg_r;
  cof_pkg::cof_item_t push_item, pop_item;
  logic               push, pop, full, empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ctype <= cof_pkg::CT_OFF;
      cfg_r.cx    <= '0;
      cfg_r.cy    <= '0;
      cfg_r.sw    <= '0;
      cfg_r.sh    <= '0;
      cfg_r.pitch <= '0;
      cfg_r.fw    <= 13'd4096;
      cfg_r.fh    <= 13'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cof_pkg::REG_CURSOR_TYPE:  cfg_r.ctype <= cfg_data[1:0];
        cof_pkg::REG_CURSOR_X:     cfg_r.cx    <= cfg_data;
        cof_pkg::REG_CURSOR_Y:     cfg_r.cy    <= cfg_data;
        cof_pkg::REG_SHAPE_WIDTH:  cfg_r.sw    <= cfg_data[6:0];
        cof_pkg::REG_SHAPE_HEIGHT: cfg_r.sh    <= cfg_data[7:0];
        cof_pkg::REG_SHAPE_PITCH:  cfg_r.pitch <= cfg_data[8:0];
        cof_pkg::REG_FRAME_WIDTH:  cfg_r.fw    <= cfg_data;
        cof_pkg::REG_FRAME_HEIGHT: cfg_r.fh    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cof_front #(
    .SHAPE_WORDS    (SHAPE_WORDS),
    .MAX_CURSOR_DIM (MAX_CURSOR_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .in_mode   (in_tuser),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  cof_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  cof_back #(
    .SHAPE_WORDS (SHAPE_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
